[hw/rtl/rde_pkg.sv]
// Shared constants, types and index helpers for the reversible deque engine.
package rde_pkg;

    localparam int DEPTH      = 1024;
    localparam int DATA_WIDTH = 16;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SUM_W      = IDX_W + 1;

    localparam int REQ_W   = 3;
    localparam int VALUE_W = 16;
    localparam int STAT_W  = 2;

    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [REQ_W-1:0]      req_code_t;
    typedef logic [STAT_W-1:0]     status_t;

    localparam req_code_t REQ_LOAD    = 3'd0;
    localparam req_code_t REQ_REVERSE = 3'd1;
    localparam req_code_t REQ_DELETE  = 3'd2;
    localparam req_code_t REQ_DRAIN   = 3'd3;
    localparam req_code_t REQ_CLEAR   = 3'd4;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_ERROR = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;
    localparam status_t ST_FULL  = 2'd3;

    // Store access issued by the controller for the current beat.
    typedef struct packed {
        logic  we;
        idx_t  waddr;
        data_t wdata;
        logic  re;
        idx_t  raddr;
    } rde_mem_cmd_t;

    // Result produced by the current beat; from_mem means the value
    // comes from the store's registered read in the following cycle.
    typedef struct packed {
        logic    valid;
        logic    from_mem;
        logic    last;
        status_t status;
    } rde_rsp_cmd_t;

    // (a + b) mod DEPTH for a, b < DEPTH: one compare and subtract.
    function automatic idx_t wrap_add(idx_t a, idx_t b);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(a) + SUM_W'(b);
        if (sum >= SUM_W'(DEPTH))
            sum = sum - SUM_W'(DEPTH);
        return sum[IDX_W-1:0];
    endfunction

endpackage

[hw/rtl/rde_if.sv]
// Request and result channel interfaces (valid/ready handshake).
interface rde_req_if
    import rde_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [REQ_W-1:0]   req_type;
    logic [VALUE_W-1:0] load_value;

    modport source (output valid, output req_type, output load_value, input ready);
    modport sink   (input valid, input req_type, input load_value, output ready);
endinterface

interface rde_rsp_if
    import rde_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [VALUE_W-1:0] out_value;
    logic              out_last;
    logic [STAT_W-1:0]  out_status;

    modport source (output valid, output out_value, output out_last, output out_status,
                    input ready);
    modport sink   (input valid, input out_value, input out_last, input out_status,
                    output ready);
endinterface

[hw/rtl/reversible_deque_engine.sv]
// Reversible deque engine: top level with store RAM, controller and result register.
//
// A ring-buffer double-ended queue with a lazy reverse flag. Each request beat is
// one of load, reverse, delete-front, drain-one or clear (codes five to seven are
// ignored). Values live in a 1024 x 16 synchronous RAM; head index, element count,
// reverse flag and sticky error flag live in the controller. A load appends at the
// physical back; the logical front is the physical back while reversed. Drain beats
// return one result: status ok with the popped value and a last mark, error after a
// delete on an empty store (until clear), or nothing left; a load into a full store
// returns a full result. Load, reverse, delete, clear and non-popping drains are
// taken back to back. A drain that pops holds the request channel off while its
// registered RAM read completes. A new request is taken while no popping drain is
// pending and the result register is empty or being emptied in the same cycle. No
// clearing pass is needed after reset: only entries inside the current count are
// ever read.

module reversible_deque_engine
    import rde_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    rde_req_if.sink       req,
    rde_rsp_if.source     rsp
);

    rde_mem_cmd_t mem_cmd;
    rde_rsp_cmd_t rsp_cmd;
    data_t        rd_data;
    logic         accept;

    // popping drain waiting for its RAM read
    logic pend_reg,      pend_next;
    logic pend_last_reg, pend_last_next;

    // result register
    logic               out_valid_reg,  out_valid_next;
    logic [VALUE_W-1:0] out_value_reg,  out_value_next;
    logic               out_last_reg,   out_last_next;
    status_t            out_status_reg, out_status_next;

    assign req.ready = !pend_reg && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    rde_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .req_type   (req.req_type),
        .load_value (req.load_value),
        .mem_cmd    (mem_cmd),
        .rsp_cmd    (rsp_cmd)
    );

    // No read/write overlap on one entry: a pop blocks the next beat until its
    // data has been captured.
    rde_ram #(
        .DATA_W (DATA_WIDTH),
        .WORDS  (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_cmd.we),
        .waddr (mem_cmd.waddr),
        .wdata (mem_cmd.wdata),
        .re    (mem_cmd.re),
        .raddr (mem_cmd.raddr),
        .rdata (rd_data)
    );

    always_comb
    begin
        pend_next       = 1'b0;
        pend_last_next  = pend_last_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;

        if (out_valid_reg && rsp.ready)
            out_valid_next = 1'b0;

        if (pend_reg)
        begin
            // result register is free here: the pop was accepted with it free
            out_valid_next  = 1'b1;
            out_value_next  = VALUE_W'(rd_data);
            out_last_next   = pend_last_reg;
            out_status_next = ST_OK;
        end
        else if (rsp_cmd.valid)
        begin
            if (rsp_cmd.from_mem)
            begin
                pend_next      = 1'b1;
                pend_last_next = rsp_cmd.last;
            end
            else
            begin
                out_valid_next  = 1'b1;
                out_value_next  = '0;
                out_last_next   = 1'b0;
                out_status_next = rsp_cmd.status;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_last_reg  <= pend_last_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.out_value  = out_value_reg;
    assign rsp.out_last   = out_last_reg;
    assign rsp.out_status = out_status_reg;

endmodule

[hw/rtl/rde_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
module rde_ram #(
    parameter int DATA_W = 16,
    parameter int WORDS  = 1024
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] waddr,
    input  logic [DATA_W-1:0]                        wdata,
    input  logic                                     re,
    input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] raddr,
    output logic [DATA_W-1:0]                        rdata
);

    logic [DATA_W-1:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

[hw/rtl/rde_ctrl.sv]
// Pointer and flag state of the deque; decodes one request per accepted beat.
module rde_ctrl
    import rde_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         accept,
    input  req_code_t    req_type,
    input  logic [VALUE_W-1:0] load_value,
    output rde_mem_cmd_t mem_cmd,
    output rde_rsp_cmd_t rsp_cmd
);

    idx_t head_reg,  head_next;
    cnt_t count_reg, count_next;
    logic rev_reg,   rev_next;
    logic err_reg,   err_next;

    logic full, empty;
    idx_t tail_slot, back_slot, head_plus1, front_slot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            rev_reg   <= 1'b0;
            err_reg   <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            rev_reg   <= rev_next;
            err_reg   <= err_next;
        end
    end

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign empty      = (count_reg == '0);
    // tail_slot used only below DEPTH; back_slot also wraps right when full
    assign tail_slot  = wrap_add(head_reg, count_reg[IDX_W-1:0]);
    assign back_slot  = wrap_add(head_reg, count_reg[IDX_W-1:0] - idx_t'(1));
    assign head_plus1 = wrap_add(head_reg, idx_t'(1));
    assign front_slot = rev_reg ? back_slot : head_reg;

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        rev_next   = rev_reg;
        err_next   = err_reg;
        mem_cmd    = '0;
        rsp_cmd    = '0;
        mem_cmd.waddr = tail_slot;
        mem_cmd.wdata = DATA_WIDTH'(load_value);
        mem_cmd.raddr = front_slot;

        if (accept)
        begin
            unique case (req_type)
                REQ_LOAD:
                begin
                    if (full)
                    begin
                        rsp_cmd.valid  = 1'b1;
                        rsp_cmd.status = ST_FULL;
                    end
                    else
                    begin
                        mem_cmd.we = 1'b1;
                        count_next = count_reg + cnt_t'(1);
                    end
                end
                REQ_REVERSE:
                    rev_next = !rev_reg;
                REQ_DELETE:
                begin
                    if (!err_reg)
                    begin
                        if (empty)
                            err_next = 1'b1;
                        else
                        begin
                            if (!rev_reg)
                                head_next = head_plus1;
                            count_next = count_reg - cnt_t'(1);
                        end
                    end
                end
                REQ_DRAIN:
                begin
                    rsp_cmd.valid = 1'b1;
                    if (err_reg)
                        rsp_cmd.status = ST_ERROR;
                    else if (empty)
                        rsp_cmd.status = ST_EMPTY;
                    else
                    begin
                        mem_cmd.re       = 1'b1;
                        rsp_cmd.from_mem = 1'b1;
                        rsp_cmd.last     = (count_reg == cnt_t'(1));
                        rsp_cmd.status   = ST_OK;
                        if (!rev_reg)
                            head_next = head_plus1;
                        count_next = count_reg - cnt_t'(1);
                    end
                end
                REQ_CLEAR:
                begin
                    head_next  = '0;
                    count_next = '0;
                    rev_next   = 1'b0;
                    err_next   = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

[tb/rde_drain_checker.sv]
`timescale 1ns / 1ps
// Shadow deque, the queue of due drain results, and the compare against the result channel.
module rde_drain_checker
    import rde_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    rde_req_if   req,
    rde_rsp_if   rsp,
    output int   fail_count,
    output int   pending,
    output int   results_seen,
    output int   values_popped
);

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               last;
        status_t            status;
    } drain_result_t;

    // The block holds at most a couple of results in flight; this is ample.
    localparam int DUE_SLOTS = 16;

    data_t         shadow_cells [DEPTH];
    idx_t          head     = '0;
    cnt_t          fill     = '0;
    logic          reversed = 1'b0;
    logic          faulted  = 1'b0;
    drain_result_t due_ring [DUE_SLOTS];
    int            due_wr   = 0;
    int            due_rd   = 0;
    drain_result_t want;

    int n_fail   = 0;
    int n_due    = 0;
    int n_seen   = 0;
    int n_popped = 0;

    assign fail_count    = n_fail;
    assign pending       = n_due;
    assign results_seen  = n_seen;
    assign values_popped = n_popped;

    // Logical front: physical back while reversed, else the head slot.
    function automatic data_t pull_logical_front();
        data_t v;
        if (reversed)
            v = shadow_cells[(int'(head) + int'(fill) - 1) % DEPTH];
        else
        begin
            v    = shadow_cells[head];
            head = idx_t'((int'(head) + 1) % DEPTH);
        end
        fill = fill - cnt_t'(1);
        return v;
    endfunction

    function automatic void add_due(status_t st, data_t v, logic last);
        drain_result_t r;
        r.value  = VALUE_W'(v);
        r.last   = last;
        r.status = st;
        if (due_wr - due_rd >= DUE_SLOTS)
        begin
            $display("%0t: too many results due: expected at most %0d, actual %0d",
                     $time, DUE_SLOTS, due_wr - due_rd + 1);
            n_fail++;
        end
        else
        begin
            due_ring[due_wr % DUE_SLOTS] = r;
            due_wr++;
        end
    endfunction

    function automatic void apply_request(req_code_t code, logic [VALUE_W-1:0] val);
        data_t v;
        case (code)
            REQ_LOAD:
                if (fill == cnt_t'(DEPTH))
                    add_due(ST_FULL, '0, 1'b0);
                else
                begin
                    shadow_cells[(int'(head) + int'(fill)) % DEPTH] = val[DATA_WIDTH-1:0];
                    fill = fill + cnt_t'(1);
                end
            REQ_REVERSE:
                reversed = !reversed;
            REQ_DELETE:
                if (!faulted)
                begin
                    if (fill == '0)
                        faulted = 1'b1;
                    else
                        void'(pull_logical_front());
                end
            REQ_DRAIN:
                if (faulted)
                    add_due(ST_ERROR, '0, 1'b0);
                else if (fill == '0)
                    add_due(ST_EMPTY, '0, 1'b0);
                else
                begin
                    v = pull_logical_front();
                    add_due(ST_OK, v, fill == '0);
                end
            REQ_CLEAR:
            begin
                head     = '0;
                fill     = '0;
                reversed = 1'b0;
                faulted  = 1'b0;
            end
            default: ;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head     = '0;
            fill     = '0;
            reversed = 1'b0;
            faulted  = 1'b0;
            due_wr   = 0;
            due_rd   = 0;
            n_due    = 0;
        end
        else
        begin
            // result beats here always belong to earlier requests: check first
            if (rsp.valid && rsp.ready)
            begin
                n_seen++;
                if (due_wr == due_rd)
                begin
                    $display("%0t: result beat with none due: expected nothing,", $time,
                             " actual value=%h last=%b status=%0d",
                             rsp.out_value, rsp.out_last, rsp.out_status);
                    n_fail++;
                end
                else
                begin
                    want = due_ring[due_rd % DUE_SLOTS];
                    due_rd++;
                    if (rsp.out_value !== want.value || rsp.out_last !== want.last ||
                        rsp.out_status !== want.status)
                    begin
                        $display("%0t: result mismatch: expected value=%h last=%b status=%0d,",
                                 $time, want.value, want.last, want.status,
                                 " actual value=%h last=%b status=%0d",
                                 rsp.out_value, rsp.out_last, rsp.out_status);
                        n_fail++;
                    end
                    else if (want.status == ST_OK)
                        n_popped++;
                end
            end
            if (req.valid && req.ready)
                apply_request(req.req_type, req.load_value);
            n_due = due_wr - due_rd;
        end
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Top of the deque engine testbench: clock, reset, stimulus, stall control and verdict.
module testbench;
    import rde_pkg::*;

    // Codes the block must ignore.
    localparam req_code_t REQ_SPARE_LO  = 3'd5;
    localparam req_code_t REQ_SPARE_MID = 3'd6;
    localparam req_code_t REQ_SPARE_HI  = 3'd7;

    // Cycles with no beat on either channel before the run is called hung.
    // Worst legal stretch is a sender gap plus a receiver stall plus a popping
    // drain, so this is far above it.
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 120;
    localparam int TAIL_ITEMS   = 40;    // last stretch runs without idling
    localparam int DRAIN_CYCLES = 8;     // settle time after the last result

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    rde_req_if req_ch ();
    rde_rsp_if rsp_ch ();

    int fail_count;
    int pending;
    int results_seen;
    int values_popped;

    int items_sent    = 0;
    int idle_cycles   = 0;
    int req_gap_pct   = 0;
    int rsp_stall_pct = 0;
    bit quiet         = 1'b0;

    reversible_deque_engine dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    rde_drain_checker drain_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .fail_count    (fail_count),
        .pending       (pending),
        .results_seen  (results_seen),
        .values_popped (values_popped)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog: any beat on either side resets the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 35;
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] any_value();
        return VALUE_W'($urandom_range(0, 16'hFFFF));
    endfunction

    // Result side: ready drops for random stretches, never in the tail.
    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 99) < rsp_stall_pct)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat.
    // valid stays high between back-to-back beats, so only one NBA per step.
    task automatic send(req_code_t code, logic [VALUE_W-1:0] val);
        if (!quiet && $urandom_range(0, 99) < req_gap_pct)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= code;
        req_ch.load_value <= val;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
        items_sent++;
    endtask

    // Sender holds off until every due result has been taken.
    task automatic wait_results_settled();
        req_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    initial
    begin : stimulus
        int random_start;
        int n;
        int pick;

        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_LOAD;
        req_ch.load_value = '0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed part ----
        send(REQ_DRAIN, '0);              // drain on empty store: nothing left
        send(REQ_DELETE, '0);             // delete on empty: sticky error set
        send(REQ_DRAIN, '0);              // error reported
        send(REQ_LOAD, 16'h1234);         // loads still land while error is set
        send(REQ_DELETE, '0);             // ignored while error is set
        send(REQ_DRAIN, '0);              // error again, store untouched
        send(REQ_CLEAR, '0);              // clears error and store
        send(REQ_LOAD, 16'h0000);
        send(REQ_LOAD, 16'hFFFF);
        send(REQ_LOAD, 16'hA5A5);
        send(REQ_REVERSE, '0);
        send(REQ_DRAIN, '0);              // reversed: physical back comes out
        send(REQ_DELETE, '0);             // reversed delete takes the back too
        send(REQ_REVERSE, '0);
        send(REQ_LOAD, 16'h5A5A);
        send(REQ_DRAIN, '0);              // forward: head element
        send(REQ_DRAIN, '0);              // last element, last mark set
        send(REQ_SPARE_LO, 16'hFFFF);     // unknown codes do nothing
        send(REQ_SPARE_MID, 16'h0000);
        send(REQ_SPARE_HI, 16'hFFFF);
        send(REQ_DRAIN, '0);
        send(REQ_REVERSE, '0);
        send(REQ_CLEAR, '0);              // clear also drops the reverse flag
        send(REQ_LOAD, 16'h0001);
        send(REQ_LOAD, 16'h0002);
        send(REQ_DRAIN, '0);
        send(REQ_DRAIN, '0);
        wait_results_settled();

        // ---- full store and slot wrap ----
        req_gap_pct   = 5;
        rsp_stall_pct = 10;
        send(REQ_CLEAR, '0);
        repeat (DEPTH) send(REQ_LOAD, any_value());
        send(REQ_LOAD, 16'hFFFF);         // full
        send(REQ_LOAD, 16'h0000);         // full
        repeat (6)
            send($urandom_range(0, 1) ? REQ_DRAIN : REQ_DELETE, '0);  // head moves up
        repeat (6) send(REQ_LOAD, any_value());   // these wrap past the last slot
        send(REQ_LOAD, 16'h1111);         // full again
        send(REQ_REVERSE, '0);
        repeat (8) send(REQ_DRAIN, '0);   // back end walks down across slot zero
        send(REQ_REVERSE, '0);
        repeat (4) send(REQ_DRAIN, '0);
        send(REQ_CLEAR, '0);
        wait_results_settled();

        // ---- random cases ----
        random_start = items_sent;
        while (items_sent < random_start + RANDOM_ITEMS)
        begin
            if (items_sent >= random_start + RANDOM_ITEMS - TAIL_ITEMS)
                quiet = 1'b1;
            req_gap_pct   = pick_pct();
            rsp_stall_pct = pick_pct();
            if ($urandom_range(0, 3) != 0)
                send(REQ_CLEAR, any_value());
            n = $urandom_range(0, 12);
            repeat (n) send(REQ_LOAD, any_value());
            n = $urandom_range(8, 30);
            repeat (n)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    send(REQ_LOAD, any_value());
                else if (pick < 45)
                    send(REQ_REVERSE, any_value());
                else if (pick < 65)
                    send(REQ_DELETE, any_value());
                else if (pick < 95)
                    send(REQ_DRAIN, any_value());
                else if (pick < 98)
                    send(REQ_CLEAR, any_value());
                else
                    send(req_code_t'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)), any_value());
            end
            if (!quiet && $urandom_range(0, 5) == 0)
                wait_results_settled();
        end

        wait_results_settled();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Run covered %0d request beats and %0d result beats,",
                 items_sent, results_seen, " %0d of them popped values.", values_popped);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[reversible_deque_engine.f]
hw/rtl/rde_pkg.sv
hw/rtl/rde_if.sv
hw/rtl/rde_ram.sv
hw/rtl/rde_ctrl.sv
hw/rtl/reversible_deque_engine.sv
tb/rde_drain_checker.sv
tb/testbench.sv
